// File: hdl/sfcpm_pkg.sv
`timescale 1ns / 1ps

package sfcpm_pkg;

  // Peak table size
  localparam int CHANNELS_DEFAULT = 32;
  localparam int CHANNEL_W        = 5;

  // Stream widths
  localparam int S_TDATA_W = 104;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 128;

  // Operation of one item
  typedef enum logic {
    MODE_DECODE = 1'b0,
    MODE_ENCODE = 1'b1
  } mode_t;

  // Raw sample formats
  typedef enum logic [2:0] {
    FMT_F32 = 3'd0,
    FMT_F64 = 3'd1,
    FMT_I32 = 3'd2,
    FMT_I16 = 3'd3,
    FMT_I24 = 3'd4
  } fmt_t;

  // Saturation values in Q1.31
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Largest peak magnitude (-1.0)
  localparam logic [31:0] PEAK_MAX = 32'h8000_0000;

  // 0.99 in Q0.16
  localparam logic [15:0] DECAY_Q16 = 16'd64881;

  // IEEE exponent fields
  localparam logic [7:0]  F32_EXP_SPECIAL = 8'hFF;
  localparam logic [7:0]  F32_EXP_ONE     = 8'd127;
  localparam logic [7:0]  F32_EXP_TOP     = 8'd126;
  localparam logic [10:0] F64_EXP_SPECIAL = 11'h7FF;
  localparam logic [10:0] F64_EXP_ONE     = 11'd1023;
  localparam logic [10:0] F64_EXP_SHIFT0  = 11'd1044;

endpackage

// File: hdl/sample_format_convert_peak_meter_core.sv
`timescale 1ns / 1ps
// An accepted item passes through the input register and then the result register.
// One item per cycle while m_axis_tready does not stall the result; all work for an item is one combinational pass
// between the input register and the result register, block maximum and peak tables
// are updated as the item moves into the result register.
// Reset (rst, synchronous, active high) clears the handshake state, the block maximum
// and both peak tables at once; no clearing pass.
module sample_format_convert_peak_meter_core #(
  parameter int CHANNELS = sfcpm_pkg::CHANNELS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // channel[4:0], raw_word[68:5], fixed_in[100:69], zero pad [103:101]
  input  logic [sfcpm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // mode[0], sample_format[3:1]
  input  logic [sfcpm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // fixed_out[31:0], raw_out[95:32], peak_level[127:96]
  output logic [sfcpm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // peak_updated
  output logic                             m_axis_tlast
);

  import sfcpm_pkg::*;

  // Only channels reachable by the 5-bit field get storage
  localparam int MAX_CH = 1 << CHANNEL_W;
  localparam int DEPTH  = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------
  // Conversion helpers
  // ---------------------------------------------------------------
  function automatic logic [31:0] neg32(input logic [31:0] v);
    return ~v + 32'd1;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? neg32(v) : v;
  endfunction

  function automatic logic [31:0] dec_f32(input logic [31:0] b);
    logic [7:0]  ef;
    logic [30:0] m;
    logic [7:0]  sh;
    logic [31:0] q;
    ef = b[30:23];
    m  = {(ef != 8'd0), b[22:0], 7'd0};
    sh = F32_EXP_TOP - ef;
    q  = {1'b0, m >> sh};
    if (ef == F32_EXP_SPECIAL) begin
      if (b[22:0] != 23'd0) return 32'd0;
      return b[31] ? SAT_NEG : SAT_POS;
    end
    if (ef >= F32_EXP_ONE) return b[31] ? SAT_NEG : SAT_POS;
    return b[31] ? neg32(q) : q;
  endfunction

  function automatic logic [31:0] dec_f64(input logic [63:0] b);
    logic [10:0] ef;
    logic [52:0] m;
    logic [10:0] sh;
    logic [52:0] q;
    ef = b[62:52];
    m  = {(ef != 11'd0), b[51:0]};
    sh = F64_EXP_SHIFT0 - ef;
    q  = m >> sh;
    if (ef == F64_EXP_SPECIAL) begin
      if (b[51:0] != 52'd0) return 32'd0;
      return b[63] ? SAT_NEG : SAT_POS;
    end
    if (ef >= F64_EXP_ONE) return b[63] ? SAT_NEG : SAT_POS;
    return b[63] ? neg32(q[31:0]) : q[31:0];
  endfunction

  // Leading zero count of a nonzero magnitude
  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  // ---------------------------------------------------------------
  // Handshake and input register
  // ---------------------------------------------------------------
  logic                  in_valid;
  logic                  in_valid_next;
  mode_t                 in_mode;
  logic [2:0]            in_fmt;
  logic [CHANNEL_W-1:0]  in_ch;
  logic [63:0]           in_raw;
  logic [31:0]           in_fx;
  logic                  in_last;
  logic                  out_free;
  logic                  move;
  logic                  s_take;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign move          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_next = in_valid;
    if (s_take) begin
      in_valid_next = 1'b1;
    end else if (move) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_mode <= mode_t'(s_axis_tuser[0]);
      in_fmt  <= s_axis_tuser[3:1];
      in_ch   <= s_axis_tdata[4:0];
      in_raw  <= s_axis_tdata[68:5];
      in_fx   <= s_axis_tdata[100:69];
      in_last <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------
  // Format conversion
  // ---------------------------------------------------------------
  logic [31:0] fx_mag;
  logic [4:0]  fx_lz;
  logic [31:0] fx_norm;
  logic [7:0]  f32_exp;
  logic [10:0] f64_exp;
  logic [31:0] q_i32;
  logic [46:0] q_i16_w;
  logic [54:0] q_i24_w;
  logic [15:0] q_i16;
  logic [23:0] q_i24;
  logic [31:0] dec_val;
  logic [63:0] enc_val;
  logic [31:0] fixed_val;
  logic [63:0] raw_val;
  logic [31:0] mag;

  assign fx_mag  = mag32(in_fx);
  assign fx_lz   = lzc32(fx_mag);
  assign fx_norm = fx_mag << fx_lz;
  assign f32_exp = 8'd127 - {3'd0, fx_lz};
  assign f64_exp = 11'd1023 - {6'd0, fx_lz};

  // x * (2^k - 1) / 2^31, truncated toward zero on the magnitude
  assign q_i32   = (fx_mag == 32'd0) ? 32'd0 : fx_mag - 32'd1;
  assign q_i16_w = {fx_mag, 15'd0} - {15'd0, fx_mag};
  assign q_i24_w = {fx_mag, 23'd0} - {23'd0, fx_mag};
  assign q_i16   = in_fx[31] ? (~q_i16_w[46:31] + 16'd1) : q_i16_w[46:31];
  assign q_i24   = in_fx[31] ? (~q_i24_w[54:31] + 24'd1) : q_i24_w[54:31];

  // Decode
  always_comb begin
    unique case (in_fmt)
      FMT_F32: dec_val = dec_f32(in_raw[31:0]);
      FMT_F64: dec_val = dec_f64(in_raw);
      FMT_I32: dec_val = in_raw[31:0];
      FMT_I16: dec_val = {in_raw[15:0], 16'd0};
      FMT_I24: dec_val = {in_raw[23:0], 8'd0};
      default: dec_val = 32'd0;
    endcase
  end

  // Encode
  always_comb begin
    unique case (in_fmt)
      FMT_F32: begin
        enc_val = (fx_mag == 32'd0) ? 64'd0 :
                  {32'd0, in_fx[31], f32_exp, fx_norm[30:8]};
      end
      FMT_F64: begin
        enc_val = (fx_mag == 32'd0) ? 64'd0 :
                  {in_fx[31], f64_exp, fx_norm[30:0], 21'd0};
      end
      FMT_I32: enc_val = {32'd0, in_fx[31] ? neg32(q_i32) : q_i32};
      FMT_I16: enc_val = {48'd0, q_i16};
      FMT_I24: enc_val = {40'd0, q_i24};
      default: enc_val = 64'd0;
    endcase
  end

  assign fixed_val = (in_mode == MODE_DECODE) ? dec_val : 32'd0;
  assign raw_val   = (in_mode == MODE_ENCODE) ? enc_val : 64'd0;
  assign mag       = (in_mode == MODE_DECODE) ? mag32(dec_val) : fx_mag;

  // ---------------------------------------------------------------
  // Block maximum and peak tables
  // ---------------------------------------------------------------
  logic [31:0]      block_max;
  logic [31:0]      block_max_next;
  logic [31:0]      bm_hit;
  logic [31:0]      in_peaks  [0:DEPTH-1];
  logic [31:0]      out_peaks [0:DEPTH-1];
  logic [IDX_W-1:0] idx;
  logic             ch_ok;
  logic [31:0]      old_peak;
  logic [47:0]      decay_prod;
  logic [31:0]      decayed;
  logic [31:0]      new_peak;
  logic [31:0]      peak_val;

  assign ch_ok      = (32'(in_ch) < 32'(DEPTH));
  assign idx        = in_ch[IDX_W-1:0];
  assign bm_hit     = (mag > block_max) ? mag : block_max;
  assign old_peak   = (in_mode == MODE_ENCODE) ? out_peaks[idx] : in_peaks[idx];
  assign decay_prod = old_peak * DECAY_Q16;
  assign decayed    = decay_prod[47:16];
  assign new_peak   = (bm_hit > decayed) ? bm_hit : decayed;
  assign peak_val   = !ch_ok ? 32'd0 : (in_last ? new_peak : old_peak);

  assign block_max_next = in_last ? 32'd0 : bm_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_max <= 32'd0;
    end else if (move) begin
      block_max <= block_max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        in_peaks[i]  <= 32'd0;
        out_peaks[i] <= 32'd0;
      end
    end else if (move && in_last && ch_ok) begin
      if (in_mode == MODE_ENCODE) begin
        out_peaks[idx] <= new_peak;
      end else begin
        in_peaks[idx] <= new_peak;
      end
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_axis_tdata <= {peak_val, raw_val, fixed_val};
      m_axis_tlast <= in_last;
    end
  end

`ifndef SYNTHESIS
  // Peak never exceeds the magnitude of -1.0
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[127:96] <= PEAK_MAX))
    else $error("peak_level above full scale");

  // Only one of the decode and encode results can be nonzero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:0] == 32'd0 || m_axis_tdata[95:32] == 64'd0))
    else $error("both fixed_out and raw_out nonzero");

  // A block-ending item clears the running maximum
  assert property (@(posedge clk) disable iff (rst)
    (move && in_last) |=> (block_max == 32'd0))
    else $error("block maximum not cleared at end of block");

  // A held item in the input register is not dropped
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> in_valid)
    else $error("input item lost while result stalled");
`endif

endmodule
